/* rtl/core/geared_multiturn_angle_tracker_core_macros.svh */
// ----------------------------------------------------------------------------
// geared multi-turn angle tracker: assertion macros
// Shared concurrent assertion forms used by the core modules.
// ----------------------------------------------------------------------------
`ifndef GEARED_MULTITURN_ANGLE_TRACKER_CORE_MACROS_SVH
`define GEARED_MULTITURN_ANGLE_TRACKER_CORE_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define GMAT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gmat assertion failed");

// next-cycle implication, ignored while reset is held
`define GMAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gmat assertion failed");

`endif

/* rtl/core/gmat_pkg.sv */
// ----------------------------------------------------------------------------
// gmat_pkg
// Types and constants shared by the geared multi-turn angle tracker core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmat_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_INV_RATIO     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATIO_SPAN    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ABSOLUTE_MODE = 2'd2;

    // q16 unity and the smallest usable gear span
    localparam logic [16:0] Q16_ONE  = 17'h10000;
    localparam logic [23:0] SPAN_MIN = 24'h010000;

    // gear accumulator carries this many bits above one turn
    localparam int GEAR_EXTRA_BITS = 8;
    localparam int REDUCE_CNT_W    = 3;

    localparam logic signed [15:0] TURN_COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TURN_COUNT_MIN = -16'sh8000;

    typedef struct packed {
        logic upd;
        logic absolute_mode;
    } turn_ctrl_t;

endpackage

/* rtl/core/gmat_turn_counter.sv */
// ----------------------------------------------------------------------------
// gmat_turn_counter
// Output-shaft wrap detector with a saturating signed turn count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "geared_multiturn_angle_tracker_core_macros.svh"

module gmat_turn_counter #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gmat_pkg::turn_ctrl_t      ctrl,
    input  logic [ANGLE_BITS-1:0]     in_turn,
    output logic signed [15:0]        turn_count_new
);

    localparam logic signed [ANGLE_BITS:0] HALF_TURN = (ANGLE_BITS+1)'(2**(ANGLE_BITS-1));

    logic [ANGLE_BITS-1:0]   prev_in_turn_reg;
    logic signed [15:0]      turn_count_reg;
    logic signed [ANGLE_BITS:0] diff;

    assign diff = $signed({1'b0, in_turn}) - $signed({1'b0, prev_in_turn_reg});

    always_comb begin
        turn_count_new = turn_count_reg;
        if (!ctrl.absolute_mode) begin
            if (diff < -HALF_TURN) begin
                if (turn_count_reg != gmat_pkg::TURN_COUNT_MAX) begin
                    turn_count_new = turn_count_reg + 16'sd1;
                end
            end else if (diff > HALF_TURN) begin
                if (turn_count_reg != gmat_pkg::TURN_COUNT_MIN) begin
                    turn_count_new = turn_count_reg - 16'sd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_in_turn_reg <= '0;
            turn_count_reg   <= '0;
        end else if (ctrl.upd) begin
            prev_in_turn_reg <= in_turn;
            turn_count_reg   <= turn_count_new;
        end
    end

    `GMAT_ASSERT_NEXT(a_count_holds_idle, aclk, aresetn, !ctrl.upd, $stable(turn_count_reg))
    `GMAT_ASSERT_NEXT(a_count_holds_abs, aclk, aresetn, ctrl.upd && ctrl.absolute_mode, $stable(turn_count_reg))
    `GMAT_ASSERT_NEXT(a_prev_tracks, aclk, aresetn, ctrl.upd, prev_in_turn_reg == $past(in_turn))

endmodule

/* rtl/core/geared_multiturn_angle_tracker_core.sv */
// ----------------------------------------------------------------------------
// geared_multiturn_angle_tracker_core
// Unwraps motor encoder samples into a geared output-shaft angle and speed.
// ----------------------------------------------------------------------------
// The core takes one encoder sample per clock while no span fold is running and
// the result side is not stalled, and returns one result per sample. The input
// register holds the accepted sample and the result register loads from it once
// the result side can take it and no fold is running. The whole step, including
// the relative-angle multiply, the gear accumulator update and the turn count,
// sits between those two registers. The first sample after reset sets the
// power-on offset. Angles use 2^ANGLE_BITS units per turn. Writing ratio_span
// marks the gear accumulator for a fold into the new span: the first geared
// sample after that write waits, with s_axis_tready low, while the fold starts
// and runs an 8-step restoring pass. Samples at ratio one never wait for a fold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "geared_multiturn_angle_tracker_core_macros.svh"

module geared_multiturn_angle_tracker_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // motor_angle, motor_speed

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // shaft_angle, shaft_angle_in_turn, shaft_speed

    input  logic                              cfg_we,
    input  logic [gmat_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [gmat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int GW = ANGLE_BITS + gmat_pkg::GEAR_EXTRA_BITS;
    localparam int DW = (ANGLE_BITS + 1 > 18) ? ANGLE_BITS + 1 : 18;
    localparam logic [15:0] ANGLE_MASK =
        (ANGLE_BITS >= 16) ? 16'hFFFF : 16'((2**ANGLE_BITS) - 1);
    localparam logic signed [DW-1:0] HALF_D = DW'(2**(ANGLE_BITS-1));

    // configuration
    logic [16:0]              inv_ratio_reg;
    logic [23:0]              ratio_span_reg;
    logic                     absolute_mode_reg;

    // input and result stages
    logic                     in_vld_reg;
    logic [15:0]              in_angle_reg;
    logic signed [15:0]       in_speed_reg;
    logic                     out_vld_reg;
    logic [63:0]              out_data_reg;

    // tracker state
    logic                     offset_valid_reg;
    logic [15:0]              offset_reg;
    logic signed [16:0]       prev_rel_reg;
    logic [GW-1:0]            gear_accum_reg;
    logic [GW-1:0]            gear_accum_next;

    // span fold, run before the first geared sample after a ratio_span write
    logic                     span_dirty_reg;
    logic                     busy_reg;
    logic [gmat_pkg::REDUCE_CNT_W-1:0] red_cnt_reg;

    logic                     fire;
    logic                     fold_start;
    logic                     ratio_one;
    logic [16:0]              inv_eff;
    logic [23:0]              span_cfg;
    logic [47:0]              span_wide;
    logic [47:0]              step_wide;
    logic [GW-1:0]            span_eff;
    logic [GW-1:0]            step;
    logic [15:0]              offset_sel;
    logic signed [16:0]       rel;
    logic signed [DW-1:0]     d;
    logic signed [GW+1:0]     acc_pm;
    logic signed [GW+1:0]     acc_mod;
    logic signed [34:0]       prod_rel;
    logic signed [47:0]       prod_rel_ext;
    logic signed [33:0]       prod_spd;
    logic [ANGLE_BITS-1:0]    in_turn;
    logic signed [15:0]       turn_count_new;
    logic signed [ANGLE_BITS+15:0] shaft_cat;
    logic signed [63:0]       shaft_ext;
    logic [GW+7:0]            span_sh;
    logic [GW+7:0]            acc_wide;
    gmat_pkg::turn_ctrl_t     turn_ctrl;

    assign fold_start    = in_vld_reg && span_dirty_reg && !ratio_one && !busy_reg;
    assign fire          = in_vld_reg && !busy_reg && !(span_dirty_reg && !ratio_one)
                           && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !busy_reg && (!in_vld_reg || fire);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    assign ratio_one = inv_ratio_reg >= gmat_pkg::Q16_ONE;
    assign inv_eff   = ratio_one ? gmat_pkg::Q16_ONE : inv_ratio_reg;
    assign span_cfg  = (ratio_span_reg < gmat_pkg::SPAN_MIN) ? gmat_pkg::SPAN_MIN
                                                               : ratio_span_reg;
    assign span_wide = {24'd0, span_cfg} << ANGLE_BITS;
    assign step_wide = {31'd0, inv_eff} << ANGLE_BITS;
    assign span_eff  = GW'(span_wide >> 16);
    assign step      = GW'(step_wide >> 16);

    assign offset_sel = offset_valid_reg ? offset_reg : in_angle_reg;
    assign rel        = $signed({1'b0, in_angle_reg}) - $signed({1'b0, offset_sel});
    assign d          = DW'(rel) - DW'(prev_rel_reg);

    // gear-side accumulator stays in [0, span)
    always_comb begin
        acc_pm = $signed({2'b00, gear_accum_reg});
        if (d < -HALF_D) begin
            acc_pm = $signed({2'b00, gear_accum_reg}) + $signed({2'b00, step});
        end else if (d > HALF_D) begin
            acc_pm = $signed({2'b00, gear_accum_reg}) - $signed({2'b00, step});
        end
        acc_mod = acc_pm;
        if (acc_pm < 0) begin
            acc_mod = acc_pm + $signed({2'b00, span_eff});
        end else if (acc_pm >= $signed({2'b00, span_eff})) begin
            acc_mod = acc_pm - $signed({2'b00, span_eff});
        end
    end

    assign prod_rel     = rel * $signed({1'b0, inv_eff});
    assign prod_rel_ext = 48'(prod_rel);
    assign prod_spd     = in_speed_reg * $signed({1'b0, inv_eff});

    assign in_turn = ratio_one ? ANGLE_BITS'(rel)
                               : ANGLE_BITS'(acc_mod) + prod_rel_ext[16 +: ANGLE_BITS];

    assign turn_ctrl.upd           = fire;
    assign turn_ctrl.absolute_mode = absolute_mode_reg;

    gmat_turn_counter #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_turn_counter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (turn_ctrl),
        .in_turn        (in_turn),
        .turn_count_new (turn_count_new)
    );

    assign shaft_cat = {turn_count_new, in_turn};
    assign shaft_ext = 64'(shaft_cat);

    // restoring fold of the accumulator, largest multiple of the span first
    assign span_sh  = (GW+8)'(span_eff) << red_cnt_reg;
    assign acc_wide = (GW+8)'(gear_accum_reg);

    always_comb begin
        gear_accum_next = gear_accum_reg;
        if (busy_reg) begin
            if (acc_wide >= span_sh) begin
                gear_accum_next = gear_accum_reg - GW'(span_sh);
            end
        end else if (fire && !ratio_one) begin
            gear_accum_next = GW'(acc_mod);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_ratio_reg     <= gmat_pkg::Q16_ONE;
            ratio_span_reg    <= gmat_pkg::SPAN_MIN;
            absolute_mode_reg <= 1'b0;
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
            offset_valid_reg  <= 1'b0;
            offset_reg        <= '0;
            prev_rel_reg      <= '0;
            gear_accum_reg    <= '0;
            span_dirty_reg    <= 1'b0;
            busy_reg          <= 1'b0;
            red_cnt_reg       <= '0;
        end else begin
            gear_accum_reg <= gear_accum_next;

            if (busy_reg) begin
                red_cnt_reg <= red_cnt_reg - 1'b1;
                if (red_cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end else if (fold_start) begin
                busy_reg       <= 1'b1;
                red_cnt_reg    <= '1;
                span_dirty_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_addr)
                    gmat_pkg::CFG_INV_RATIO: begin
                        inv_ratio_reg <= cfg_wdata[16:0];
                    end
                    gmat_pkg::CFG_RATIO_SPAN: begin
                        ratio_span_reg <= cfg_wdata;
                        span_dirty_reg <= 1'b1;
                    end
                    gmat_pkg::CFG_ABSOLUTE_MODE: begin
                        absolute_mode_reg <= cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end

            if (fire) begin
                out_vld_reg      <= 1'b1;
                offset_valid_reg <= 1'b1;
                offset_reg       <= offset_sel;
                if (!ratio_one) begin
                    prev_rel_reg <= rel;
                end
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_angle_reg <= s_axis_tdata[15:0] & ANGLE_MASK;
            in_speed_reg <= $signed(s_axis_tdata[31:16]);
        end
        if (fire) begin
            out_data_reg <= {prod_spd[31:16], 16'(in_turn), shaft_ext[31:0]};
        end
    end

    `GMAT_ASSERT_NOW(a_busy_blocks_input, aclk, aresetn, busy_reg, !s_axis_tready)
    `GMAT_ASSERT_NOW(a_accum_in_span, aclk, aresetn, !busy_reg && !span_dirty_reg, gear_accum_reg < span_eff)
    `GMAT_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, out_vld_reg)

endmodule

/* tb/tb_geared_multiturn_angle_tracker_core.sv */
// ----------------------------------------------------------------------------
// tb_geared_multiturn_angle_tracker_core
// Drives encoder samples into the tracker core and checks every result
// against the table or an in-bench model of the offset latch, the gear accumulator
// and the output-shaft turn counter. A short table covers the hand-checkable cases
// and runs the turn count up and back down through zero. Random phases then run
// under a range of gear settings. Both stream sides idle at random throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_geared_multiturn_angle_tracker_core;

    localparam int  ANGLE_BITS     = 16;
    localparam int  CYCLE_LIMIT    = 4_000_000;
    localparam int  RANDOM_PHASES  = 10;
    localparam int  PHASE_SAMPLES  = 80;
    localparam int  SETTLE_CYCLES  = 10;

    typedef struct packed {
        logic [31:0] shaft_angle;
        logic [15:0] in_turn;
        logic [15:0] shaft_speed;
    } shaft_result_t;

    typedef struct packed {
        logic          reconfig;
        logic [16:0]   inv;
        logic [23:0]   span;
        logic          absolute;
        logic [15:0]   angle;
        logic [15:0]   stride;
        logic [17:0]   reps;
        logic [15:0]   speed;
        logic          rand_speed;
        logic          typed;
        shaft_result_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 15;

    // reconfig, inv, span, absolute, angle, stride, reps, speed, rand, typed, want
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // first sample after reset becomes the zero reference
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1234, 16'h0000, 18'd1, 16'h8000, 1'b0, 1'b1,
          '{32'h0000_0000, 16'h0000, 16'h8000}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1233, 16'h0000, 18'd1, 16'h7FFF, 1'b0, 1'b1,
          '{32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1234, 16'h0000, 18'd1, 16'h0000, 1'b0, 1'b1,
          '{32'h0000_0000, 16'h0000, 16'h0000}},
        // exactly half a turn either way is not a wrap; one step past half is
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h9234, 16'h0000, 18'd1, 16'hFFFF, 1'b0, 1'b1,
          '{32'h0000_8000, 16'h8000, 16'hFFFF}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1234, 16'h0000, 18'd1, 16'h0001, 1'b0, 1'b1,
          '{32'h0000_0000, 16'h0000, 16'h0001}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h9235, 16'h0000, 18'd1, 16'h0100, 1'b0, 1'b1,
          '{32'hFFFF_8001, 16'h8001, 16'h0100}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1234, 16'h0000, 18'd1, 16'h8001, 1'b0, 1'b1,
          '{32'h0000_0000, 16'h0000, 16'h8001}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'hFFFF, 16'h0001, 18'd2, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        // one turn every two samples: count up, then back down through zero
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1234, 16'h7FFF, 18'd40, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        '{1'b0, 17'h0, 24'h0, 1'b0, 16'h1234, 16'h8001, 18'd80, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        // zero reciprocal
        '{1'b1, 17'h00000, 24'h010000, 1'b0, 16'h4000, 16'h0000, 18'd3, 16'h7FFF, 1'b0, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        // span below one turn, counting held
        '{1'b1, 17'h08000, 24'h000000, 1'b1, 16'h0000, 16'h6000, 18'd40, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        // reciprocal above unity falls back to ratio one
        '{1'b1, 17'h1FFFF, 24'hFFFFFF, 1'b0, 16'h0000, 16'h9000, 18'd24, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        '{1'b1, 17'h00001, 24'hFFFFFF, 1'b0, 16'h0000, 16'h7FFF, 18'd24, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}},
        '{1'b1, 17'h08000, 24'h00FFFF, 1'b0, 16'h8000, 16'hC001, 18'd40, 16'h0000, 1'b1, 1'b0,
          '{32'h0, 16'h0, 16'h0}}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // motor_angle, motor_speed

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // shaft_angle, shaft_angle_in_turn, shaft_speed

    logic                            cfg_we    = 1'b0;
    logic [gmat_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [gmat_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // model copy of the registers
    logic [16:0] ratio_inv;
    logic [23:0] gear_span;
    logic        count_off;

    // model copy of the tracking state
    logic        zero_latched;
    logic [15:0] zero_angle;
    longint      last_rel;
    longint      gear_acc;
    logic [15:0] last_in_turn;
    int          turns;

    shaft_result_t pending_results[$];
    int            err_count   = 0;
    int            cycle_count = 0;
    int            burst_left  = 1;
    logic [15:0]   ready_mask  = '1;
    int            ready_phase = 0;

    geared_multiturn_angle_tracker_core #(
        .ANGLE_BITS (ANGLE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic void apply_reg(input logic [gmat_pkg::CFG_ADDR_W-1:0] idx,
                                      input logic [gmat_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            gmat_pkg::CFG_INV_RATIO:     ratio_inv = val[16:0];
            gmat_pkg::CFG_RATIO_SPAN:    gear_span = val[23:0];
            gmat_pkg::CFG_ABSOLUTE_MODE: count_off = val[0];
            default: ;
        endcase
    endfunction

    function automatic shaft_result_t track_sample(input logic [15:0] ang,
                                                   input logic [15:0] spd_raw);
        longint        inv;
        longint        rel;
        longint        d;
        longint        acc;
        longint        span;
        longint        scaled;
        longint        e;
        longint        shaft;
        longint        spd;
        logic          unity;
        logic [15:0]   turn_pos;
        shaft_result_t r;

        unity = (ratio_inv >= 17'h10000);
        inv   = unity ? 64'sd65536 : longint'(ratio_inv);
        if (!zero_latched) begin
            zero_angle   = ang;
            zero_latched = 1'b1;
        end
        rel = longint'(ang) - longint'(zero_angle);

        if (unity) begin
            turn_pos = 16'(rel);
        end else begin
            span = (gear_span < 24'h010000) ? 64'sd65536 : longint'(gear_span);
            d    = rel - last_rel;
            acc  = gear_acc;
            // a jump past half a motor turn moves the gear by one motor turn
            if (d < -32768) begin
                acc = acc + inv;
            end else if (d > 32768) begin
                acc = acc - inv;
            end
            acc = acc % span;
            if (acc < 0) begin
                acc = acc + span;
            end
            gear_acc = acc;
            last_rel = rel;
            scaled   = (rel * inv) >>> 16;
            turn_pos = 16'(acc + scaled);
        end

        e = longint'(turn_pos) - longint'(last_in_turn);
        if (!count_off) begin
            if (e < -32768) begin
                if (turns < 32767) turns++;
            end else if (e > 32768) begin
                if (turns > -32768) turns--;
            end
        end
        last_in_turn = turn_pos;

        shaft = longint'(turns) * 65536 + longint'(turn_pos);
        spd   = (longint'($signed(spd_raw)) * inv) >>> 16;

        r.shaft_angle = 32'(shaft);
        r.in_turn     = turn_pos;
        r.shaft_speed = 16'(spd);
        return r;
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [15:0] ang, input logic [15:0] spd,
                               input logic typed, input shaft_result_t want);
        shaft_result_t model_out;
        int            gap;

        s_axis_tdata  <= {spd, ang};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        model_out = track_sample(ang, spd);
        pending_results.push_back(typed ? want : model_out);

        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
            gap        = $urandom_range(0, 4);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // stay idle before the registers change
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gmat_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [gmat_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_tracking(input logic [16:0] inv, input logic [23:0] span,
                                input logic absolute);
        drain_results();
        // unused upper bits are junk on purpose
        write_reg(gmat_pkg::CFG_INV_RATIO, {7'($urandom), inv});
        write_reg(gmat_pkg::CFG_ABSOLUTE_MODE, {23'($urandom), absolute});
        write_reg(gmat_pkg::CFG_RATIO_SPAN, span);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_monitor
        shaft_result_t want;
        shaft_result_t got;

        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.shaft_angle = m_axis_tdata[31:0];
            got.in_turn     = m_axis_tdata[47:32];
            got.shaft_speed = m_axis_tdata[63:48];
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing expected: %h", $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.shaft_angle !== want.shaft_angle) begin
                    err_count++;
                    $display("%0t: shaft_angle expected %h actual %h",
                             $time, want.shaft_angle, got.shaft_angle);
                end
                if (got.in_turn !== want.in_turn) begin
                    err_count++;
                    $display("%0t: shaft_angle_in_turn expected %h actual %h",
                             $time, want.in_turn, got.in_turn);
                end
                if (got.shaft_speed !== want.shaft_speed) begin
                    err_count++;
                    $display("%0t: shaft_speed expected %h actual %h",
                             $time, want.shaft_speed, got.shaft_speed);
                end
            end
        end

        // receiver stall pattern, reshuffled each time ready_phase wraps
        if (ready_phase == 15) begin
            case ($urandom_range(0, 3))
                0:       ready_mask <= '1;
                1:       ready_mask <= 16'($urandom);
                2:       ready_mask <= 16'($urandom | $urandom);
                default: ready_mask <= 16'($urandom & $urandom);
            endcase
        end
        ready_phase   <= (ready_phase + 1) % 16;
        m_axis_tready <= ready_mask[ready_phase];
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t   row;
        logic [15:0] ang;
        logic [15:0] cur_angle;
        logic [15:0] delta;
        logic [16:0] inv;
        logic [23:0] span;
        logic        absolute;

        ratio_inv    = 17'h10000;
        gear_span    = 24'h010000;
        count_off    = 1'b0;
        zero_latched = 1'b0;
        zero_angle   = '0;
        last_rel     = 0;
        gear_acc     = 0;
        last_in_turn = '0;
        turns        = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.reconfig) begin
                set_tracking(row.inv, row.span, row.absolute);
            end
            ang = row.angle;
            for (int k = 0; k < int'(row.reps); k++) begin
                push_sample(ang, row.rand_speed ? pick_speed() : row.speed,
                            row.typed, row.want);
                ang = ang + row.stride;
            end
        end

        cur_angle = ang;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin inv = 17'h10000; span = 24'h010000; absolute = 1'b0; end
                1: begin inv = 17'h08000; span = 24'h020000; absolute = 1'b0; end
                2: begin inv = 17'd21845; span = 24'h030000; absolute = 1'b1; end
                3: begin inv = 17'h00000; span = 24'h010000; absolute = 1'b0; end
                4: begin inv = 17'h1FFFF; span = 24'hFFFFFF; absolute = 1'b0; end
                5: begin inv = 17'h00001; span = 24'hFFFFFF; absolute = 1'b0; end
                9: begin
                    inv      = 17'($urandom);
                    span     = 24'($urandom);
                    absolute = 1'($urandom);
                end
                default: begin
                    inv      = 17'($urandom_range(1, 16'hFFFF));
                    span     = 24'($urandom);
                    absolute = 1'($urandom);
                end
            endcase
            set_tracking(inv, span, absolute);

            for (int k = 0; k < PHASE_SAMPLES; k++) begin
                if (p == 6 && k == PHASE_SAMPLES / 2) begin
                    drain_results();
                end
                case ($urandom_range(0, 19))
                    // smooth motion either way
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                        delta = 16'($urandom_range(0, 16'h6FFF));
                    end
                    // around half a turn, on both sides of the wrap threshold
                    12, 13, 14, 15: begin
                        delta = 16'($urandom_range(16'h7F00, 16'h8100));
                    end
                    16, 17: begin
                        delta = 16'($urandom_range(0, 1));
                    end
                    default: begin
                        delta = 16'($urandom);
                    end
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    cur_angle = cur_angle + delta;
                end else begin
                    cur_angle = cur_angle - delta;
                end
                push_sample(cur_angle, pick_speed(), 1'b0, '0);
            end
        end

        drain_results();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
